// ===== rtl/ffp_pkg.sv =====
// shared types, constants and the month name table of the timestamp parser
// no dependencies; imported by every module of the block

package ffp_pkg;

  localparam int unsigned FfpQueueDepth = 2;

  localparam int unsigned NumMonths = 12;

  localparam logic [7:0] MonthNames [NumMonths][3] = '{
    '{"j", "a", "n"}, '{"f", "e", "b"}, '{"m", "a", "r"}, '{"a", "p", "r"},
    '{"m", "a", "y"}, '{"j", "u", "n"}, '{"j", "u", "l"}, '{"a", "u", "g"},
    '{"s", "e", "p"}, '{"o", "c", "t"}, '{"n", "o", "v"}, '{"d", "e", "c"}
  };

  localparam logic [4:0] PosMonthLast = 5'd2;
  localparam logic [4:0] PosDaySep    = 5'd3;
  localparam logic [4:0] PosDayLast   = 5'd5;
  localparam logic [4:0] PosHourSep   = 5'd6;
  localparam logic [4:0] PosHourLast  = 5'd8;
  localparam logic [4:0] PosMinSep    = 5'd9;
  localparam logic [4:0] PosMinLast   = 5'd11;
  localparam logic [4:0] PosSecSep    = 5'd12;
  localparam logic [4:0] PosSecLast   = 5'd14;
  localparam logic [4:0] PosYearSep   = 5'd15;
  localparam logic [4:0] PosYearLast  = 5'd19;

  localparam logic [13:0] MaxDay   = 14'd31;
  localparam logic [13:0] MaxHour  = 14'd24;
  localparam logic [13:0] MaxMin   = 14'd60;
  localparam logic [13:0] YearBase = 14'd1900;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChColon = 8'h3a;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StBadMonth  = 3'd1,
    StBadSep    = 3'd2,
    StNonDigit  = 3'd3,
    StBadRange  = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       start_req;
  } ffp_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [12:0] year_offset;
    logic [4:0]  fail_position;
  } ffp_out_t;

  typedef struct packed {
    logic       start;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_space;
    logic       is_colon;
    logic [7:0] fchar;
  } ffp_cls_t;

endpackage

// ===== rtl/ffp_front.sv =====
// front end: classifies each incoming byte (case fold, digit, separators)
// depends on ffp_pkg

module ffp_front import ffp_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ffp_in_t  in_data_i,
  output logic     push_valid_o,
  input  logic     push_ready_i,
  output ffp_cls_t push_data_o
);

  logic [7:0] c;

  assign c            = in_data_i.char_byte;
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  always_comb begin
    push_data_o.start    = in_data_i.start_req;
    push_data_o.is_digit = (c >= "0") && (c <= "9");
    push_data_o.digit    = c[3:0];
    push_data_o.is_space = (c == ChSpace);
    push_data_o.is_colon = (c == ChColon);
    if ((c >= "A") && (c <= "Z")) begin
      push_data_o.fchar = c + 8'd32;
    end else begin
      push_data_o.fchar = c;
    end
  end

endmodule

// ===== rtl/ffp_queue.sv =====
// short queue of classified bytes between front and back end
// depends on ffp_pkg

module ffp_queue import ffp_pkg::*; #(
  parameter int unsigned Depth = FfpQueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  ffp_cls_t push_data_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output ffp_cls_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ffp_cls_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/ffp_back.sv =====
// back end: position tracking, month match, digit accumulation, range checks
// and the output register; depends on ffp_pkg

module ffp_back import ffp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     pop_valid_i,
  output logic     pop_ready_o,
  input  ffp_cls_t pop_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ffp_out_t out_data_o
);

  logic             active_q, active_d;
  logic [4:0]       pos_q, pos_d;
  logic [11:0]      cand_q, cand_d;
  logic [13:0]      acc_q, acc_d;
  logic [3:0]       month_q, month_d;
  logic [4:0]       day_q, day_d, hour_q, hour_d;
  logic [5:0]       min_q, min_d, sec_q, sec_d;
  logic             out_valid_q;
  ffp_out_t         out_q;

  logic             fire, eff_active, emit;
  logic [4:0]       eff_pos;
  logic [11:0]      eff_cand, keep, new_cand;
  logic [13:0]      eff_acc, acc_next;
  logic [3:0]       eff_month, month_enc;
  logic [4:0]       eff_day, eff_hour;
  logic [5:0]       eff_min, eff_sec;
  logic [1:0]       name_idx;
  status_e          status;
  logic [12:0]      year_off;
  logic [4:0]       fail_pos;

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign fire        = pop_valid_i && pop_ready_o;
  assign eff_active  = pop_data_i.start || active_q;
  assign eff_pos     = pop_data_i.start ? '0 : pos_q;
  assign eff_cand    = pop_data_i.start ? '1 : cand_q;
  assign eff_acc     = pop_data_i.start ? '0 : acc_q;
  assign eff_month   = pop_data_i.start ? '0 : month_q;
  assign eff_day     = pop_data_i.start ? '0 : day_q;
  assign eff_hour    = pop_data_i.start ? '0 : hour_q;
  assign eff_min     = pop_data_i.start ? '0 : min_q;
  assign eff_sec     = pop_data_i.start ? '0 : sec_q;
  assign name_idx    = (eff_pos <= PosMonthLast) ? eff_pos[1:0] : 2'd0;
  assign acc_next    = 14'(eff_acc * 14'd10) + 14'(pop_data_i.digit);
  assign new_cand    = eff_cand & keep;

  always_comb begin
    keep      = '0;
    month_enc = '0;
    for (int i = 0; i < NumMonths; i++) begin
      keep[i] = (MonthNames[i][name_idx] == pop_data_i.fchar);
    end
    for (int i = NumMonths - 1; i >= 0; i--) begin
      if (new_cand[i]) begin
        month_enc = 4'(i);
      end
    end
  end

  always_comb begin
    emit     = 1'b0;
    status   = StOk;
    fail_pos = eff_pos;
    year_off = '0;
    pos_d    = eff_pos + 5'd1;
    cand_d   = eff_cand;
    acc_d    = eff_acc;
    month_d  = eff_month;
    day_d    = eff_day;
    hour_d   = eff_hour;
    min_d    = eff_min;
    sec_d    = eff_sec;
    if (eff_pos <= PosMonthLast) begin
      cand_d = new_cand;
      if (new_cand == '0) begin
        emit   = 1'b1;
        status = StBadMonth;
      end else if (eff_pos == PosMonthLast) begin
        month_d = month_enc;
      end
    end else if (eff_pos == PosDaySep || eff_pos == PosHourSep || eff_pos == PosYearSep) begin
      acc_d = '0;
      if (!pop_data_i.is_space) begin
        emit   = 1'b1;
        status = StBadSep;
      end
    end else if (eff_pos == PosMinSep || eff_pos == PosSecSep) begin
      acc_d = '0;
      if (!pop_data_i.is_colon) begin
        emit   = 1'b1;
        status = StBadSep;
      end
    end else if (!pop_data_i.is_digit) begin
      emit   = 1'b1;
      status = StNonDigit;
    end else begin
      acc_d = acc_next;
      case (eff_pos)
        PosDayLast: begin
          if (acc_next > MaxDay) begin
            emit   = 1'b1;
            status = StBadRange;
          end
          day_d = acc_next[4:0];
        end
        PosHourLast: begin
          if (acc_next > MaxHour) begin
            emit   = 1'b1;
            status = StBadRange;
          end
          hour_d = acc_next[4:0];
        end
        PosMinLast: begin
          if (acc_next > MaxMin) begin
            emit   = 1'b1;
            status = StBadRange;
          end
          min_d = acc_next[5:0];
        end
        PosSecLast: begin
          if (acc_next > MaxMin) begin
            emit   = 1'b1;
            status = StBadRange;
          end
          sec_d = acc_next[5:0];
        end
        PosYearLast: begin
          emit = 1'b1;
          if (acc_next < YearBase) begin
            status = StBadRange;
          end else begin
            fail_pos = '0;
            year_off = 13'(acc_next - YearBase);
          end
        end
        default: begin
        end
      endcase
    end
    active_d = !emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pos_q    <= '0;
      cand_q   <= '1;
      acc_q    <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      min_q    <= '0;
      sec_q    <= '0;
    end else if (fire && eff_active) begin
      active_q <= active_d;
      pos_q    <= pos_d;
      cand_q   <= cand_d;
      acc_q    <= acc_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      min_q    <= min_d;
      sec_q    <= sec_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && eff_active && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && eff_active && emit) begin
      out_q.status        <= status;
      out_q.month         <= eff_month;
      out_q.day_of_month  <= eff_day;
      out_q.hour          <= eff_hour;
      out_q.minute        <= eff_min;
      out_q.second        <= eff_sec;
      out_q.year_offset   <= year_off;
      out_q.fail_position <= fail_pos;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/fixed_format_timestamp_parser_core.sv =====
// Parser for fixed-format timestamps such as "Nov 24 18:22:48 1986", one byte per
// transfer, start_req on the first byte. While no unaccepted result holds the
// output register, sustained rate is one byte per clock and the back end takes
// one queued byte per cycle. Results leave through that register. Bytes outside
// an open string are dropped; a new start abandons an open string silently.
// Depends on ffp_pkg, ffp_front, ffp_queue and ffp_back.

module fixed_format_timestamp_parser_core import ffp_pkg::*; #(
  parameter int unsigned QueueDepth = FfpQueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ffp_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ffp_out_t out_data_o
);

  logic     push_valid, push_ready, pop_valid, pop_ready;
  ffp_cls_t push_data, pop_data;

  ffp_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  ffp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  ffp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/ffp_checker.sv =====
// port-level checks of the timestamp parser, bound to the top level
// depends on ffp_pkg

module ffp_checker import ffp_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input ffp_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input ffp_out_t out_data_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("byte changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_ok_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StOk |->
      out_data_o.fail_position == '0 && out_data_o.month <= 4'd11 &&
      out_data_o.day_of_month <= 5'd31 && out_data_o.hour <= 5'd24 &&
      out_data_o.minute <= 6'd60 && out_data_o.second <= 6'd60)
    else $error("ok result with bad fields");

  a_month_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StBadMonth |->
      out_data_o.fail_position <= 5'd2 && out_data_o.month == '0 &&
      out_data_o.day_of_month == '0 && out_data_o.year_offset == '0)
    else $error("month failure with bad fields");

  a_fail_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != StOk |->
      out_data_o.year_offset == '0 && out_data_o.status <= StBadRange &&
      out_data_o.fail_position <= 5'd19)
    else $error("failure result with bad fields");

endmodule

bind fixed_format_timestamp_parser_core ffp_checker u_ffp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== tb/tb_timestamp_checker.sv =====
// checker for the timestamp parser: watches both transfer channels, predicts each result
// from the accepted bytes and compares it field by field; depends on ffp_pkg

module tb_timestamp_checker import ffp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  ffp_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  ffp_out_t    out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [8*36-1:0] MonthLetters = "janfebmaraprmayjunjulaugsepoctnovdec";

  logic [4:0]  pos_q;
  logic        open_q;
  logic [11:0] mon_mask_q;
  logic [13:0] acc_q;
  logic [3:0]  mon_q;
  logic [4:0]  day_q;
  logic [4:0]  hour_q;
  logic [5:0]  min_q;
  logic [5:0]  sec_q;

  ffp_out_t expected_stamps [$];

  function automatic void clear_stamp();
    pos_q      = '0;
    mon_mask_q = '1;
    acc_q      = '0;
    mon_q      = '0;
    day_q      = '0;
    hour_q     = '0;
    min_q      = '0;
    sec_q      = '0;
  endfunction

  function automatic ffp_out_t close_stamp(status_e st, logic [12:0] yr, logic [4:0] at);
    ffp_out_t r;
    r.status        = st;
    r.month         = mon_q;
    r.day_of_month  = day_q;
    r.hour          = hour_q;
    r.minute        = min_q;
    r.second        = sec_q;
    r.year_offset   = yr;
    r.fail_position = at;
    open_q = 1'b0;
    return r;
  endfunction

  function automatic bit parse_timestamp_byte(input ffp_in_t b, output ffp_out_t res);
    logic [7:0]  c;
    logic [11:0] keep;
    c   = b.char_byte;
    res = '0;
    if (b.start_req) begin
      clear_stamp();
      open_q = 1'b1;
    end
    if (!open_q) return 1'b0;
    if (pos_q > 5'd19) begin
      res = close_stamp(StBadSep, '0, 5'd19);
      return 1'b1;
    end
    if (pos_q <= 5'd2) begin
      if (c >= "A" && c <= "Z") c = c + 8'd32;
      keep = '0;
      for (int i = 0; i < 12; i++) begin
        if (MonthLetters[8 * (35 - (3 * i + pos_q)) +: 8] == c) keep[i] = 1'b1;
      end
      mon_mask_q &= keep;
      if (mon_mask_q == '0) begin
        res = close_stamp(StBadMonth, '0, pos_q);
        return 1'b1;
      end
      if (pos_q == 5'd2) begin
        for (int i = 11; i >= 0; i--) begin
          if (mon_mask_q[i]) mon_q = 4'(i);
        end
      end
    end else if (pos_q == 5'd3 || pos_q == 5'd6 || pos_q == 5'd15) begin
      if (c != " ") begin
        res = close_stamp(StBadSep, '0, pos_q);
        return 1'b1;
      end
      acc_q = '0;
    end else if (pos_q == 5'd9 || pos_q == 5'd12) begin
      if (c != ":") begin
        res = close_stamp(StBadSep, '0, pos_q);
        return 1'b1;
      end
      acc_q = '0;
    end else begin
      if (c < "0" || c > "9") begin
        res = close_stamp(StNonDigit, '0, pos_q);
        return 1'b1;
      end
      acc_q = 14'(acc_q * 10 + (c - "0"));
      case (pos_q)
        5'd5: begin
          if (acc_q > 31) begin
            res = close_stamp(StBadRange, '0, pos_q);
            return 1'b1;
          end
          day_q = acc_q[4:0];
        end
        5'd8: begin
          if (acc_q > 24) begin
            res = close_stamp(StBadRange, '0, pos_q);
            return 1'b1;
          end
          hour_q = acc_q[4:0];
        end
        5'd11: begin
          if (acc_q > 60) begin
            res = close_stamp(StBadRange, '0, pos_q);
            return 1'b1;
          end
          min_q = acc_q[5:0];
        end
        5'd14: begin
          if (acc_q > 60) begin
            res = close_stamp(StBadRange, '0, pos_q);
            return 1'b1;
          end
          sec_q = acc_q[5:0];
        end
        5'd19: begin
          if (acc_q < 1900) begin
            res = close_stamp(StBadRange, '0, pos_q);
            return 1'b1;
          end
          res = close_stamp(StOk, 13'(acc_q - 14'd1900), '0);
          return 1'b1;
        end
        default: ;
      endcase
    end
    pos_q = pos_q + 5'd1;
    return 1'b0;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ffp_out_t exp_r;
    ffp_out_t got;
    if (!rst_ni) begin
      clear_stamp();
      open_q = 1'b0;
      expected_stamps.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_stamps.size() == 0) begin
          $error("result transfer with no expected stamp: %h", out_data_i);
          fail_count_o++;
        end else begin
          exp_r = expected_stamps.pop_front();
          check_field("status", exp_r.status, out_data_i.status);
          check_field("month", exp_r.month, out_data_i.month);
          check_field("day_of_month", exp_r.day_of_month, out_data_i.day_of_month);
          check_field("hour", exp_r.hour, out_data_i.hour);
          check_field("minute", exp_r.minute, out_data_i.minute);
          check_field("second", exp_r.second, out_data_i.second);
          check_field("year_offset", exp_r.year_offset, out_data_i.year_offset);
          check_field("fail_position", exp_r.fail_position, out_data_i.fail_position);
        end
      end
      if (in_valid_i && in_ready_i && parse_timestamp_byte(in_data_i, got)) begin
        expected_stamps.push_back(got);
      end
    end
    pending_o = expected_stamps.size();
  end

endmodule

// ===== tb/tb_fixed_format_timestamp_parser_core.sv =====
// top of the timestamp parser testbench: clock, reset, byte stimulus and the verdict
// depends on ffp_pkg, fixed_format_timestamp_parser_core and tb_timestamp_checker

module tb_fixed_format_timestamp_parser_core;

  timeunit 1ns;
  timeprecision 1ps;

  import ffp_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam logic [8*36-1:0] MonthLetters = "janfebmaraprmayjunjulaugsepoctnovdec";

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  ffp_in_t     in_data = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  ffp_out_t    out_data;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned snd_idle = 0;
  int unsigned rcv_idle = 0;

  fixed_format_timestamp_parser_core i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  tb_timestamp_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_byte(input ffp_in_t b);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte('{char_byte: s[i], start_req: (i == 0)});
    end
  endtask

  function automatic int unsigned edge_pick(int unsigned hi);
    case ($urandom_range(3))
      0: return 0;
      1: return hi;
      default: return $urandom_range(hi);
    endcase
  endfunction

  task automatic send_random_stamps(input int unsigned n_bytes);
    string       txt;
    string       mon;
    int unsigned kind;
    int unsigned len;
    int unsigned mi;
    int unsigned at;
    int unsigned d, h, mn, se, yr;
    int unsigned counted;
    counted = 0;
    mon = "jan";
    while (counted < n_bytes) begin
      kind = $urandom_range(99);
      mi = $urandom_range(11);
      for (int p = 0; p < 3; p++) begin
        mon[p] = MonthLetters[8 * (35 - (3 * mi + p)) +: 8];
        if ($urandom_range(1)) mon[p] = mon[p] - 8'd32;
      end
      d  = edge_pick(31);
      h  = edge_pick(24);
      mn = edge_pick(60);
      se = edge_pick(60);
      yr = 1900 + edge_pick(8099);
      if (kind >= 55 && kind < 70) begin
        case ($urandom_range(4))
          0: d  = $urandom_range(99, 32);
          1: h  = $urandom_range(99, 25);
          2: mn = $urandom_range(99, 61);
          3: se = $urandom_range(99, 61);
          default: yr = $urandom_range(1) ? 1899 : $urandom_range(1899);
        endcase
      end
      txt = $sformatf("%s %02d %02d:%02d:%02d %04d", mon, d, h, mn, se, yr);
      len = 20;
      if (kind >= 70 && kind < 85) begin
        at = $urandom_range(19);
        txt[at] = $urandom_range(1) ? 8'($urandom_range(255, 1)) : 8'($urandom_range("z", "a"));
      end else if (kind >= 85 && kind < 93) begin
        len = $urandom_range(19, 1);
      end
      for (int i = 0; i < len; i++) begin
        send_byte('{char_byte: txt[i], start_req: (i == 0 || $urandom_range(199) == 0)});
        counted++;
      end
      if (kind >= 93) begin
        repeat ($urandom_range(4, 1)) begin
          send_byte('{char_byte: 8'($urandom_range(255)), start_req: ($urandom_range(9) == 0)});
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    snd_idle = 19;
    rcv_idle = 57;

    send_text("Jan 00 00:00:00 1900");
    send_text("dEC 31 24:60:60 9999");
    send_byte('{char_byte: 8'hc1, start_req: 1'b1});
    send_text("Jx");
    send_text("Nox");
    send_text("Nov-");
    send_text("Nov 2a");
    send_text("Nov 32");
    send_text("mAy 31 24:60:60 1899");
    // abandoned string, then bytes outside any string
    send_text("Sep 1");
    send_text("jun 00 00:00:00 1900");
    send_byte('{char_byte: 8'hff, start_req: 1'b0});
    send_byte('{char_byte: 8'h00, start_req: 1'b0});

    send_random_stamps(610);
    snd_idle = 57;
    rcv_idle = 19;
    send_random_stamps(610);
    snd_idle = 0;
    rcv_idle = 0;
    send_random_stamps(610);
    in_valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ffp_pkg.sv
rtl/ffp_front.sv
rtl/ffp_queue.sv
rtl/ffp_back.sv
rtl/fixed_format_timestamp_parser_core.sv
rtl/ffp_checker.sv
tb/tb_timestamp_checker.sv
tb/tb_fixed_format_timestamp_parser_core.sv
